@@ sv/mhc_pkg.sv @@
package mhc_pkg;

    localparam int WIN_DEPTH  = 13;
    localparam int TYPE_LEN   = 13;
    localparam int PREFIX_LEN = 8;
    localparam int CNT_W      = $clog2(WIN_DEPTH + 1);

    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_UP_A  = 8'h41;
    localparam logic [7:0] CHR_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_GAP  = 8'h20;

    // "content-type:" in lower case; the first PREFIX_LEN bytes are "content-"
    localparam logic [7:0] TYPE_PATTERN [TYPE_LEN] = '{
        8'h63, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74,
        8'h2D, 8'h74, 8'h79, 8'h70, 8'h65, 8'h3A
    };

    typedef enum logic [1:0] {
        CLASS_MESSAGE = 2'd0,
        CLASS_CONTENT = 2'd1,
        CLASS_TYPE    = 2'd2
    } t_class;

    typedef struct packed {
        logic [7:0] out_byte;
        t_class     header_class;
        logic       field_start;
        logic       block_last;
    } t_result;

    // only A-Z fold to lower case
    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CHR_UP_A && c <= CHR_UP_Z) begin
            r = c + CASE_GAP;
        end
        return r;
    endfunction

endpackage

@@ sv/mhc_in_if.sv @@
interface mhc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_block;

    modport source (output valid, output in_byte, output end_of_block, input ready);
    modport sink   (input valid, input in_byte, input end_of_block, output ready);
endinterface

@@ sv/mhc_out_if.sv @@
interface mhc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] header_class;
    logic       field_start;
    logic       block_last;

    modport source (output valid, output out_byte, output header_class,
                    output field_start, output block_last, input ready);
    modport sink   (input valid, input out_byte, input header_class,
                    input field_start, input block_last, output ready);
endinterface

@@ sv/mhc_match.sv @@
// Case-insensitive compare of the window view against the pattern and its prefix.
module mhc_match (
    input  logic [7:0]                 i_bytes [mhc_pkg::WIN_DEPTH],
    input  logic [mhc_pkg::WIN_DEPTH-1:0] i_valid,
    output mhc_pkg::t_class            o_class
);

    logic [mhc_pkg::TYPE_LEN-1:0] hit;
    logic                         type_ok;
    logic                         prefix_ok;

    always_comb begin
        for (int k = 0; k < mhc_pkg::TYPE_LEN; k++) begin
            hit[k] = i_valid[k] && (mhc_pkg::fold(i_bytes[k]) == mhc_pkg::TYPE_PATTERN[k]);
        end
        type_ok   = &hit;
        prefix_ok = &hit[mhc_pkg::PREFIX_LEN-1:0];
        if (type_ok) begin
            o_class = mhc_pkg::CLASS_TYPE;
        end else if (prefix_ok) begin
            o_class = mhc_pkg::CLASS_CONTENT;
        end else begin
            o_class = mhc_pkg::CLASS_MESSAGE;
        end
    end

endmodule

@@ sv/mhc_out_buf.sv @@
// Two-entry result buffer; the upstream side sees only the registered fill.
module mhc_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mhc_pkg::t_result i_data,
    output logic             o_space,
    mhc_out_if.source        o_out
);

    mhc_pkg::t_result r_slot0, n_slot0;
    mhc_pkg::t_result r_slot1, n_slot1;
    logic [1:0]       r_cnt, n_cnt;
    logic             pop;

    assign pop     = o_out.valid && o_out.ready;
    assign o_space = (r_cnt != 2'd2);

    always_comb begin
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        n_cnt   = r_cnt;
        if (pop) begin
            n_slot0 = r_slot1;
        end
        if (i_push) begin
            if ((r_cnt == 2'd0) || (r_cnt == 2'd1 && pop)) begin
                n_slot0 = i_data;
            end else begin
                n_slot1 = i_data;
            end
        end
        n_cnt = r_cnt + 2'(i_push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

    assign o_out.valid        = (r_cnt != 2'd0);
    assign o_out.out_byte     = r_slot0.out_byte;
    assign o_out.header_class = r_slot0.header_class;
    assign o_out.field_start  = r_slot0.field_start;
    assign o_out.block_last   = r_slot0.block_last;

endmodule

@@ sv/mail_header_classifier_top.sv @@
// Mail header field splitter and classifier. Header bytes enter one per request
// and leave twelve positions later, each tagged with its field's class
// (message header, other Content- header, Content-Type header) and a
// field-start flag. In steady state, while the output buffer has space, one
// byte is taken and one result is given every cycle; the first twelve bytes of
// a block give no result. The byte marked end_of_block flushes the window:
// after it the input stalls while the held bytes (up to thirteen) drain one
// per cycle whenever the buffer has space, the last carrying block_last.
// Results wait in a two-entry buffer, so input keeps flowing while one result
// waits to be taken. The match on a field looks at its first 13 bytes even
// where they run into the next field; bytes beyond the block end never match.
module mail_header_classifier_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mhc_in_if.sink    i_in,
    mhc_out_if.source o_out
);

    localparam int D = mhc_pkg::WIN_DEPTH;
    localparam int W = mhc_pkg::CNT_W;

    // window: slot 0 oldest; slots below r_count hold bytes
    logic [7:0]     r_win   [D];
    logic [7:0]     n_win   [D];
    logic [D-1:0]   r_start, n_start;
    logic [W-1:0]   r_count, n_count;
    logic           r_prev_nl, n_prev_nl;
    logic           r_in_block, n_in_block;
    logic           r_draining, n_draining;
    mhc_pkg::t_class r_class, n_class;

    // view of the window with the incoming byte appended
    logic [7:0]     v_byte  [D];
    logic [D-1:0]   v_valid;
    logic [D-1:0]   v_start;

    logic            space;
    logic            acc;
    logic            drain_emit;
    logic            emit;
    logic            starts;
    logic [7:0]      b;
    mhc_pkg::t_class match_class;
    mhc_pkg::t_class class_now;
    mhc_pkg::t_result res;

    assign b          = i_in.in_byte;
    assign i_in.ready = !r_draining && space;
    assign acc        = i_in.valid && i_in.ready;
    assign drain_emit = r_draining && space;

    // a field starts on the first byte of a block, or after CR/LF unless the
    // byte continues a folded line (space, tab) or is the LF of a CRLF
    assign starts = !r_in_block ||
                    (r_prev_nl && b != mhc_pkg::CHR_SPACE && b != mhc_pkg::CHR_TAB &&
                     b != mhc_pkg::CHR_LF);

    always_comb begin
        for (int k = 0; k < D; k++) begin
            if (W'(k) < r_count) begin
                v_byte[k]  = r_win[k];
                v_valid[k] = 1'b1;
                v_start[k] = r_start[k];
            end else if (acc && W'(k) == r_count) begin
                v_byte[k]  = b;
                v_valid[k] = 1'b1;
                v_start[k] = starts;
            end else begin
                v_byte[k]  = r_win[k];
                v_valid[k] = 1'b0;
                v_start[k] = 1'b0;
            end
        end
    end

    mhc_match u_match (
        .i_bytes (v_byte),
        .i_valid (v_valid),
        .o_class (match_class)
    );

    // class is decided when a field's first byte is the oldest slot
    assign class_now = v_start[0] ? match_class : r_class;

    // steady-state emit happens once the window is full with the new byte
    assign emit = (acc && !i_in.end_of_block && r_count == W'(D - 1)) || drain_emit;

    assign res.out_byte     = v_byte[0];
    assign res.header_class = class_now;
    assign res.field_start  = v_start[0];
    assign res.block_last   = drain_emit && (r_count == W'(1));

    always_comb begin
        n_win      = r_win;
        n_start    = r_start;
        n_count    = r_count;
        n_prev_nl  = r_prev_nl;
        n_in_block = r_in_block;
        n_draining = r_draining;
        n_class    = r_class;

        if (emit) begin
            n_class = class_now;
            for (int k = 0; k < D - 1; k++) begin
                n_win[k]   = v_byte[k + 1];
                n_start[k] = v_start[k + 1];
            end
            n_win[D-1]   = v_byte[D-1];
            n_start[D-1] = 1'b0;
        end else if (acc) begin
            n_win   = v_byte;
            n_start = v_start;
        end

        if (acc) begin
            n_prev_nl  = (b == mhc_pkg::CHR_CR) || (b == mhc_pkg::CHR_LF);
            n_in_block = 1'b1;
            if (i_in.end_of_block) begin
                n_count    = r_count + W'(1);
                n_draining = 1'b1;
            end else if (!emit) begin
                n_count = r_count + W'(1);
            end
        end

        if (drain_emit) begin
            n_count = r_count - W'(1);
            if (r_count == W'(1)) begin
                // block done: back to the reset picture
                n_draining = 1'b0;
                n_prev_nl  = 1'b0;
                n_in_block = 1'b0;
                n_class    = mhc_pkg::CLASS_MESSAGE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_prev_nl  <= 1'b0;
            r_in_block <= 1'b0;
            r_draining <= 1'b0;
            r_class    <= mhc_pkg::CLASS_MESSAGE;
            r_start    <= '0;
        end else begin
            r_count    <= n_count;
            r_prev_nl  <= n_prev_nl;
            r_in_block <= n_in_block;
            r_draining <= n_draining;
            r_class    <= n_class;
            r_start    <= n_start;
        end
        r_win <= n_win;
    end

    mhc_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (emit),
        .i_data  (res),
        .o_space (space),
        .o_out   (o_out)
    );

endmodule

@@ verif/mail_header_classifier_top_tb.sv @@
`timescale 1ns / 100ps
module mail_header_classifier_top_tb;

    logic i_clk;
    logic i_rst_n;

    mhc_in_if  req_if();
    mhc_out_if res_if();

    mail_header_classifier_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if.sink),
        .o_out   (res_if.source)
    );

    // 2 ns clock
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // idle percentages for sender and receiver
    int unsigned src_gap_pct;
    int unsigned sink_stall_pct;
    int unsigned fault_count;

    // tagged bytes the block still owes, oldest first
    mhc_pkg::t_result tagged_bytes_due [$];

    // bytes of the block being built for sending
    logic [7:0] block_bytes [$];

    // ---------------------------------------------------------------
    // Classifier shadow: 13-slot window, slot 0 oldest
    // ---------------------------------------------------------------
    logic [7:0]      slot_byte  [mhc_pkg::WIN_DEPTH];
    logic            slot_full  [mhc_pkg::WIN_DEPTH];
    logic            slot_first [mhc_pkg::WIN_DEPTH];
    logic            saw_newline;
    mhc_pkg::t_class live_class;
    logic            mid_block;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= mhc_pkg::CHR_UP_A && c <= mhc_pkg::CHR_UP_Z) ? (c | 8'h20) : c;
    endfunction

    // window agrees with the first n pattern bytes; empty slots never agree
    function automatic logic slots_match(input int n);
        logic ok;
        ok = 1'b1;
        for (int k = 0; k < n; k++) begin
            if (!slot_full[k] || to_lower(slot_byte[k]) != mhc_pkg::TYPE_PATTERN[k]) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic int slots_held();
        int n;
        n = 0;
        while (n < mhc_pkg::WIN_DEPTH && slot_full[n]) begin
            n++;
        end
        return n;
    endfunction

    task automatic clear_window();
        for (int i = 0; i < mhc_pkg::WIN_DEPTH; i++) begin
            slot_byte[i]  = 8'h00;
            slot_full[i]  = 1'b0;
            slot_first[i] = 1'b0;
        end
        saw_newline = 1'b0;
        live_class  = mhc_pkg::CLASS_MESSAGE;
        mid_block   = 1'b0;
    endtask

    // Class is decided when a field's first byte is oldest in the window.
    task automatic emit_oldest_slot(input logic last);
        mhc_pkg::t_result r;
        if (slot_first[0]) begin
            if (slots_match(mhc_pkg::TYPE_LEN)) begin
                live_class = mhc_pkg::CLASS_TYPE;
            end else if (slots_match(mhc_pkg::PREFIX_LEN)) begin
                live_class = mhc_pkg::CLASS_CONTENT;
            end else begin
                live_class = mhc_pkg::CLASS_MESSAGE;
            end
        end
        r.out_byte     = slot_byte[0];
        r.header_class = live_class;
        r.field_start  = slot_first[0];
        r.block_last   = last;
        tagged_bytes_due.push_back(r);
        for (int i = 0; i < mhc_pkg::WIN_DEPTH - 1; i++) begin
            slot_byte[i]  = slot_byte[i + 1];
            slot_full[i]  = slot_full[i + 1];
            slot_first[i] = slot_first[i + 1];
        end
        slot_byte[mhc_pkg::WIN_DEPTH - 1]  = 8'h00;
        slot_full[mhc_pkg::WIN_DEPTH - 1]  = 1'b0;
        slot_first[mhc_pkg::WIN_DEPTH - 1] = 1'b0;
    endtask

    task automatic classify_request(input logic [7:0] b, input logic eob);
        logic starts;
        int   held;
        // first byte of a block, or a non-continuation byte after CR/LF
        starts = !mid_block ||
                 (saw_newline && b != mhc_pkg::CHR_SPACE && b != mhc_pkg::CHR_TAB &&
                  b != mhc_pkg::CHR_LF);
        saw_newline = (b == mhc_pkg::CHR_CR || b == mhc_pkg::CHR_LF);
        mid_block   = 1'b1;
        held = slots_held();
        if (held >= mhc_pkg::WIN_DEPTH) begin
            emit_oldest_slot(1'b0);
            held = mhc_pkg::WIN_DEPTH - 1;
        end
        slot_byte[held]  = b;
        slot_full[held]  = 1'b1;
        slot_first[held] = starts;
        held++;
        if (!eob) begin
            if (held == mhc_pkg::WIN_DEPTH) begin
                emit_oldest_slot(1'b0);
            end
        end else begin
            // flush: drain everything, block_last on the final one
            while (held > 0) begin
                emit_oldest_slot(held == 1);
                held--;
            end
            clear_window();
        end
    endtask

    // ---------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------
    // Holds valid across back-to-back requests; only drops it in a gap.
    task automatic send_request(input logic [7:0] b, input logic eob);
        while ($urandom_range(99) < src_gap_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.in_byte      <= b;
        req_if.end_of_block <= eob;
        @(posedge i_clk);
        while (!req_if.ready) begin
            @(posedge i_clk);
        end
        classify_request(b, eob);
    endtask

    task automatic send_block();
        for (int i = 0; i < block_bytes.size(); i++) begin
            send_request(block_bytes[i], i == block_bytes.size() - 1);
        end
    endtask

    task automatic add_text(input string s, input bit mix_case);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (mix_case && ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z"))
                && $urandom_range(1) == 1) begin
                c = c ^ 8'h20;
            end
            block_bytes.push_back(c);
        end
    endtask

    task automatic add_printable(input int n);
        for (int i = 0; i < n; i++) begin
            block_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
        end
    endtask

    // CRLF, bare LF or bare CR
    task automatic add_line_end();
        case ($urandom_range(2))
            0: begin
                block_bytes.push_back(mhc_pkg::CHR_CR);
                block_bytes.push_back(mhc_pkg::CHR_LF);
            end
            1: block_bytes.push_back(mhc_pkg::CHR_LF);
            default: block_bytes.push_back(mhc_pkg::CHR_CR);
        endcase
    endtask

    task automatic add_field_name();
        case ($urandom_range(11))
            0, 1, 2: add_text("Content-Type:", 1'b1);
            3:  add_text("Content-Transfer-Encoding:", 1'b1);
            4:  add_text("Content-ID:", 1'b1);
            5:  add_text("Content-Typ", 1'b1);
            6:  add_text("Content_Type:", 1'b1);
            7:  add_text("Contents:", 1'b1);
            8:  add_text("Subject:", 1'b1);
            9:  add_text("From:", 1'b1);
            10: add_text("Received:", 1'b1);
            default: add_text("X-Mailer:", 1'b1);
        endcase
    endtask

    // well-formed header lines with random content, sometimes folded,
    // sometimes cut short so the last match runs off the block end
    task automatic build_header_block();
        int fields;
        int cut;
        fields = $urandom_range(1, 4);
        for (int f = 0; f < fields; f++) begin
            add_field_name();
            block_bytes.push_back(mhc_pkg::CHR_SPACE);
            add_printable($urandom_range(0, 6));
            if ($urandom_range(3) == 0) begin
                add_line_end();
                block_bytes.push_back($urandom_range(1) ? mhc_pkg::CHR_SPACE
                                                        : mhc_pkg::CHR_TAB);
                add_printable($urandom_range(0, 4));
            end
            add_line_end();
        end
        if ($urandom_range(3) == 0) begin
            cut = $urandom_range(0, block_bytes.size() - 1);
            repeat (cut) void'(block_bytes.pop_back());
        end
    endtask

    // arbitrary bytes with line breaks and whitespace mixed in
    task automatic build_noise_block();
        int n;
        n = $urandom_range(1, 16);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(7))
                0: block_bytes.push_back(mhc_pkg::CHR_CR);
                1: block_bytes.push_back(mhc_pkg::CHR_LF);
                2: block_bytes.push_back($urandom_range(1) ? mhc_pkg::CHR_SPACE
                                                           : mhc_pkg::CHR_TAB);
                default: block_bytes.push_back(8'($urandom_range(255)));
            endcase
        end
    endtask

    // ---------------------------------------------------------------
    // Result side: random stalls, in-order compare
    // ---------------------------------------------------------------
    task automatic note_fault(input string what, input mhc_pkg::t_result want,
                              input bit have_want);
        fault_count++;
        if (fault_count <= 10) begin
            if (have_want) begin
                $display("%s: expected byte %02h class %0d start %0b last %0b, ",
                         what, want.out_byte, want.header_class, want.field_start,
                         want.block_last,
                         "got byte %02h class %0d start %0b last %0b",
                         res_if.out_byte, res_if.header_class,
                         res_if.field_start, res_if.block_last);
            end else begin
                $display("%s: byte %02h class %0d start %0b last %0b", what,
                         res_if.out_byte, res_if.header_class, res_if.field_start,
                         res_if.block_last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        mhc_pkg::t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (tagged_bytes_due.size() == 0) begin
                want = '0;
                note_fault("unexpected result", want, 1'b0);
            end else begin
                want = tagged_bytes_due.pop_front();
                if (res_if.out_byte !== want.out_byte ||
                    res_if.header_class !== want.header_class ||
                    res_if.field_start !== want.field_start ||
                    res_if.block_last !== want.block_last) begin
                    note_fault("mismatch", want, 1'b1);
                end
            end
        end
        res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // one-byte blocks at both byte extremes: start, flush and last together
    task automatic test_lone_bytes();
        send_request(8'h00, 1'b1);
        send_request(8'hFF, 1'b1);
    endtask

    // exactly one window of upper-case pattern, flushed by its own last byte
    task automatic test_full_window_type();
        block_bytes.delete();
        add_text("CONTENT-TYPE:", 1'b0);
        send_block();
    endtask

    // prefix-only match, CRLF and tab continuation kept in the field,
    // new field after LF whose match runs past the block end
    task automatic test_folding_and_prefix();
        block_bytes.delete();
        add_text("cOntent-", 1'b0);
        block_bytes.push_back(mhc_pkg::CHR_CR);
        block_bytes.push_back(mhc_pkg::CHR_LF);
        block_bytes.push_back(mhc_pkg::CHR_TAB);
        add_text("Z", 1'b0);
        block_bytes.push_back(mhc_pkg::CHR_LF);
        add_text("Q", 1'b0);
        send_block();
    endtask

    task automatic test_random_headers(input int budget);
        int sent;
        sent = 0;
        while (sent < budget) begin
            block_bytes.delete();
            if ($urandom_range(9) < 8) begin
                build_header_block();
            end else begin
                build_noise_block();
            end
            if (block_bytes.size() == 0) begin
                build_noise_block();
            end
            send_block();
            sent += block_bytes.size();
        end
    endtask

    initial begin
        fault_count    = 0;
        src_gap_pct    = 15;
        sink_stall_pct = 71;
        clear_window();
        i_rst_n             <= 1'b0;
        req_if.valid        <= 1'b0;
        req_if.in_byte      <= 8'h00;
        req_if.end_of_block <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_lone_bytes();
        test_full_window_type();
        test_folding_and_prefix();
        test_random_headers(80);

        src_gap_pct    = 71;
        sink_stall_pct = 15;
        test_random_headers(80);

        src_gap_pct    = 0;
        sink_stall_pct = 0;
        test_random_headers(80);

        req_if.valid <= 1'b0;
        while (tagged_bytes_due.size() != 0) begin
            @(posedge i_clk);
        end
        // let any stray output show up
        repeat (40) @(posedge i_clk);
        if (tagged_bytes_due.size() != 0) begin
            fault_count++;
        end
        if (fault_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #200000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/mhc_pkg.sv
sv/mhc_in_if.sv
sv/mhc_out_if.sv
sv/mhc_match.sv
sv/mhc_out_buf.sv
sv/mail_header_classifier_top.sv
verif/mail_header_classifier_top_tb.sv
